@@ design/ldiv_pkg.sv @@
// Shared types and constants for the limb divider by an invariant divisor.
// Used by ldiv_ctrl, ldiv_datapath and limb_divide_by_invariant_core.
`default_nettype none

package ldiv_pkg;

  localparam int DEFAULT_LIMB_WIDTH = 32;
  localparam int FIELD_WIDTH        = 32;
  localparam int CFG_DATA_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int SHIFT_WIDTH        = 5;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIVISOR    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECIPROCAL = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT      = 2'd2;

  localparam logic [CFG_DATA_WIDTH-1:0] DIVISOR_RESET = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PREP,
    OP_TAIL,
    OP_MUL1,
    OP_SUM,
    OP_MUL2,
    OP_FIX1,
    OP_FIX2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_TAIL,
    S_MUL1,
    S_SUM,
    S_MUL2,
    S_FIX1,
    S_FIX2,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic load_in;
    logic emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic direct;    // item yields one word without a division step
    logic step;      // item needs a division step
    logic tail;      // last item needs the closing division step
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/limb_divide_by_invariant_core.sv @@
// Top level of the limb divider by an invariant one-limb divisor.
// Instantiates ldiv_ctrl and ldiv_datapath; uses ldiv_pkg.
//
// Divides a dividend streamed most significant limb first by a normalized
// divisor with a precomputed reciprocal (2-by-1 step with two corrections).
// One item is worked at a time: after prep it returns to idle, goes to emit
// for a word without a division step, or runs the multiply and correct steps
// before emit; a last item with a nonzero shift adds the closing step. Emit
// waits on m_axis_tready. Each division step runs two registered LIMB_WIDTH
// x LIMB_WIDTH multiplies and two corrections in sequence. The output
// register holds one result while the next item is taken in. Configuration
// must be written only while no item is in flight; the block does not check.
`default_nettype none

module limb_divide_by_invariant_core
  import ldiv_pkg::*;
#(
  parameter int LIMB_WIDTH = DEFAULT_LIMB_WIDTH
)
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [FIELD_WIDTH-1:0]     s_axis_tdata,   // limb
  input  wire logic                       s_axis_tuser,   // first_limb
  input  wire logic                       s_axis_tlast,   // last_limb
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [2*FIELD_WIDTH-1:0]        m_axis_tdata,   // quotient_limb, remainder
  output logic                            m_axis_tlast    // last_result
);

  cmd_t                  cmd;
  status_t               st;
  logic [LIMB_WIDTH-1:0] quotient, remainder;

  ldiv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ldiv_datapath #(
    .LIMB_WIDTH (LIMB_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_limb       (s_axis_tdata),
    .in_first      (s_axis_tuser),
    .in_last       (s_axis_tlast),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_quotient  (quotient),
    .out_remainder (remainder),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {FIELD_WIDTH'(remainder), FIELD_WIDTH'(quotient)};

endmodule

`default_nettype wire

@@ design/ldiv_ctrl.sv @@
// Sequencer for the limb divider: accepts an item, steps the datapath
// through the 2-by-1 division cycles and result hand-off. Uses ldiv_pkg.
`default_nettype none

module ldiv_ctrl
  import ldiv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;
  logic   tail_pending, tail_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tail_pending <= 1'b0;
    end else begin
      state        <= state_next;
      tail_pending <= tail_pending_next;
    end
  end

  always_comb begin
    state_next        = state;
    tail_pending_next = tail_pending;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        tail_pending_next = st.tail;
        if (st.direct)    state_next = S_EMIT;
        else if (st.step) state_next = S_MUL1;
        else if (st.tail) state_next = S_TAIL;
        else              state_next = S_IDLE;
      end
      S_TAIL: begin
        tail_pending_next = 1'b0;
        state_next        = S_MUL1;
      end
      S_MUL1: state_next = S_SUM;
      S_SUM:  state_next = S_MUL2;
      S_MUL2: state_next = S_FIX1;
      S_FIX1: state_next = S_FIX2;
      S_FIX2: state_next = S_EMIT;
      S_EMIT: begin
        if (st.out_free) state_next = tail_pending ? S_TAIL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.load_in   = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_last = st.last & ~tail_pending;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_PREP: cmd.op = OP_PREP;
      S_TAIL: cmd.op = OP_TAIL;
      S_MUL1: cmd.op = OP_MUL1;
      S_SUM:  cmd.op = OP_SUM;
      S_MUL2: cmd.op = OP_MUL2;
      S_FIX1: cmd.op = OP_FIX1;
      S_FIX2: cmd.op = OP_FIX2;
      S_EMIT: cmd.emit = st.out_free;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/ldiv_datapath.sv @@
// Datapath of the limb divider: configuration registers, running remainder,
// held limb, multiply / correct step registers and the output register.
// Driven by ldiv_ctrl through cmd_t / status_t from ldiv_pkg.
`default_nettype none

module ldiv_datapath
  import ldiv_pkg::*;
#(
  parameter int LIMB_WIDTH = DEFAULT_LIMB_WIDTH
)
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic [FIELD_WIDTH-1:0]     in_limb,
  input  wire logic                       in_first,
  input  wire logic                       in_last,
  input  wire cmd_t                       cmd,
  output status_t                         st,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [LIMB_WIDTH-1:0]           out_quotient,
  output logic [LIMB_WIDTH-1:0]           out_remainder,
  output logic                            out_last
);

  localparam int W  = LIMB_WIDTH;
  localparam int W2 = 2 * LIMB_WIDTH;
  localparam int SW = $clog2(LIMB_WIDTH);

  logic [W-1:0]           d_reg, v_reg;
  logic [SHIFT_WIDTH-1:0] shift_reg;
  logic [W-1:0]           rem, held;
  logic                   merge;

  logic [W-1:0]  a_reg;
  logic          first_reg, last_reg;
  logic [W-1:0]  hi_r, lo_r, q0_r, q1_r, prod2, r_r, qword;
  logic [W2-1:0] prod1;

  logic [SW-1:0] s_eff;
  logic [SW:0]   rs;
  logic          zero_shift, a_below, ge_d, fix1_hit;
  logic [W-1:0]  d_shr, a_top, step_lo, tail_lo, fix1_r;
  logic [W2-1:0] sum_q;

  always_comb begin
    if (int'(shift_reg) >= W) s_eff = SW'(W - 1);
    else                      s_eff = shift_reg[SW-1:0];
  end

  assign rs         = (SW+1)'(W) - {1'b0, s_eff};
  assign zero_shift = (s_eff == '0);
  assign d_shr      = d_reg >> s_eff;
  assign a_below    = a_reg < d_shr;
  assign ge_d       = a_reg >= d_reg;
  assign a_top      = a_reg >> rs;
  assign step_lo    = (held << s_eff) | a_top;
  assign tail_lo    = held << s_eff;
  assign sum_q      = prod1 + {hi_r, lo_r};
  assign fix1_r     = lo_r - prod2;
  assign fix1_hit   = fix1_r > q0_r;

  always_comb begin
    st.direct   = first_reg & (zero_shift | a_below);
    st.step     = ~first_reg & (zero_shift | ~merge);
    st.tail     = ~zero_shift & last_reg & ~(first_reg & a_below);
    st.last     = last_reg;
    st.out_free = ~out_valid | out_ready;
  end

  // state that the reset defines
  always_ff @(posedge clk) begin
    if (rst) begin
      d_reg     <= DIVISOR_RESET[W-1:0];
      v_reg     <= '1;
      shift_reg <= '0;
      rem       <= '0;
      held      <= '0;
      merge     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIVISOR:    d_reg     <= cfg_data[W-1:0];
          REG_RECIPROCAL: v_reg     <= cfg_data[W-1:0];
          REG_SHIFT:      shift_reg <= cfg_data[SHIFT_WIDTH-1:0];
          default:        ;
        endcase
      end
      case (cmd.op)
        OP_PREP: begin
          held  <= a_reg;
          merge <= ~zero_shift & first_reg & a_below & ~last_reg;
          if (first_reg) begin
            if (zero_shift)   rem <= ge_d ? a_reg - d_reg : a_reg;
            else if (a_below) rem <= a_reg << s_eff;
            else              rem <= a_top;
          end else if (~zero_shift & merge) begin
            rem <= rem | a_top;
          end
        end
        OP_FIX2: rem <= (r_r >= d_reg) ? r_r - d_reg : r_r;
        default: ;
      endcase
      if (cmd.emit)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_reg     <= in_limb[W-1:0];
      first_reg <= in_first;
      last_reg  <= in_last;
    end
    case (cmd.op)
      OP_PREP: begin
        qword <= zero_shift ? W'(ge_d) : '0;
        hi_r  <= rem;
        lo_r  <= zero_shift ? a_reg : step_lo;
      end
      OP_TAIL: begin
        hi_r <= rem;
        lo_r <= tail_lo;
      end
      OP_MUL1: prod1 <= W2'(hi_r) * W2'(v_reg);
      OP_SUM: begin
        q0_r <= sum_q[W-1:0];
        q1_r <= sum_q[W2-1:W] + W'(1);
      end
      OP_MUL2: prod2 <= q1_r * d_reg;
      OP_FIX1: begin
        if (fix1_hit) begin
          q1_r <= q1_r - W'(1);
          r_r  <= fix1_r + d_reg;
        end else begin
          r_r  <= fix1_r;
        end
      end
      OP_FIX2: qword <= (r_r >= d_reg) ? q1_r + W'(1) : q1_r;
      default: ;
    endcase
    if (cmd.emit) begin
      out_quotient  <= qword;
      out_remainder <= cmd.emit_last ? rem >> s_eff : '0;
      out_last      <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire
